// File: hw/rtl/morse_two_bit_symbol_decoder_core_assert.svh
// Assertion macros for the Morse two-bit symbol decoder core.
// Used by the checker module; no other dependencies.
`ifndef MORSE_TWO_BIT_SYMBOL_DECODER_CORE_ASSERT_SVH
`define MORSE_TWO_BIT_SYMBOL_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTBSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtbsd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MTBSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtbsd assertion failed");

`endif

// File: hw/rtl/mtbsd_pkg.sv
// Shared types, constants and the Morse code table for the decoder core.
// No dependencies.
`timescale 1ns / 1ps

package mtbsd_pkg;

    localparam int ACC_BITS_DEF = 16;
    localparam int CHAR_W       = 7;
    localparam int SYMS         = 4;
    localparam int KEY_W        = 32;

    localparam logic [1:0] SYM_END   = 2'b00;
    localparam logic [1:0] SYM_SPACE = 2'b11;

    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

    // Decoded characters of one beat, slot 0 is the first (MSB) symbol.
    typedef struct packed {
        logic [SYMS-1:0]             mask;
        logic [SYMS-1:0][CHAR_W-1:0] chars;
    } mtbsd_res_t;

    // Dot = 10, dash = 01, first symbol in the upper bits.
    function automatic logic [CHAR_W-1:0] morse_lookup(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] ch;
        case (key)
            32'b10_01:                ch = 7'h41; // A
            32'b01_10_10_10:          ch = 7'h42; // B
            32'b01_10_01_10:          ch = 7'h43; // C
            32'b01_10_10:             ch = 7'h44; // D
            32'b10:                   ch = 7'h45; // E
            32'b10_10_01_10:          ch = 7'h46; // F
            32'b01_01_10:             ch = 7'h47; // G
            32'b10_10_10_10:          ch = 7'h48; // H
            32'b10_10:                ch = 7'h49; // I
            32'b10_01_01_01:          ch = 7'h4A; // J
            32'b01_10_01:             ch = 7'h4B; // K
            32'b10_01_10_10:          ch = 7'h4C; // L
            32'b01_01:                ch = 7'h4D; // M
            32'b01_10:                ch = 7'h4E; // N
            32'b01_01_01:             ch = 7'h4F; // O
            32'b10_01_01_10:          ch = 7'h50; // P
            32'b01_01_10_01:          ch = 7'h51; // Q
            32'b10_01_10:             ch = 7'h52; // R
            32'b10_10_10:             ch = 7'h53; // S
            32'b01:                   ch = 7'h54; // T
            32'b10_10_01:             ch = 7'h55; // U
            32'b10_10_10_01:          ch = 7'h56; // V
            32'b10_01_01:             ch = 7'h57; // W
            32'b01_10_10_01:          ch = 7'h58; // X
            32'b01_10_01_01:          ch = 7'h59; // Y
            32'b01_01_10_10:          ch = 7'h5A; // Z
            32'b01_01_01_01_01:       ch = 7'h30; // 0
            32'b10_01_01_01_01:       ch = 7'h31; // 1
            32'b10_10_01_01_01:       ch = 7'h32; // 2
            32'b10_10_10_01_01:       ch = 7'h33; // 3
            32'b10_10_10_10_01:       ch = 7'h34; // 4
            32'b10_10_10_10_10:       ch = 7'h35; // 5
            32'b01_10_10_10_10:       ch = 7'h36; // 6
            32'b01_01_10_10_10:       ch = 7'h37; // 7
            32'b01_01_01_10_10:       ch = 7'h38; // 8
            32'b01_01_01_01_10:       ch = 7'h39; // 9
            32'b10_01_01_01_01_10:    ch = 7'h27; // '
            32'b10_01_01_10_01_10:    ch = 7'h40; // @
            32'b01_01_01_10_10_10:    ch = 7'h3A; // :
            32'b01_01_10_10_01_01:    ch = 7'h2C; // ,
            32'b10_10_10_01_10_10_01: ch = 7'h24; // $
            32'b01_10_10_10_01:       ch = 7'h3D; // =
            32'b01_10_01_10_01_01:    ch = 7'h21; // !
            32'b10_01_10_01_10_01:    ch = 7'h2E; // .
            32'b10_10_01_01_10_10:    ch = 7'h3F; // ?
            32'b10_01_10_10_01_10:    ch = 7'h22; // "
            default:                  ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

endpackage

// File: hw/rtl/morse_two_bit_symbol_decoder_core.sv
// Flow: an accepted beat is held in the input register, then decoded and loaded
// into the result buffer once that buffer is free; characters leave from there.
// Throughput: one character per cycle while text_stall is low, through the
// single-character output port; a new beat can wait in the input register meanwhile.
// Reset (rst_n, async low): accumulator cleared, input and result buffers empty.
`timescale 1ns / 1ps

module morse_two_bit_symbol_decoder_core #(
    parameter int ACC_BITS = mtbsd_pkg::ACC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // code beats in
    input  logic                          code_valid,
    output logic                          code_stall,
    input  logic [7:0]                    code_byte,
    // characters out
    output logic                          text_valid,
    input  logic                          text_stall,
    output logic [mtbsd_pkg::CHAR_W-1:0]  text_char,
    output logic                          last_of_byte
);
    import mtbsd_pkg::*;

    // Input register: holds one beat until the result buffer can take it.
    logic                in_valid_reg, in_valid_next;
    logic [7:0]          byte_reg;

    // Code accumulator, advanced when a beat is decoded.
    logic [ACC_BITS-1:0] acc_reg, acc_next, acc_dec;

    // Result buffer: the decoded characters of one beat and the ones still owed.
    logic [SYMS-1:0]             mask_reg, mask_next;
    logic [SYMS-1:0][CHAR_W-1:0] chars_reg;

    mtbsd_res_t          dec_res;
    logic [SYMS-1:0]     mask_rest;
    logic [1:0]          sel;
    logic                text_fire, code_fire, buf_free, load;

    mtbsd_decode #(
        .ACC_BITS (ACC_BITS)
    ) u_decode (
        .code_byte (byte_reg),
        .acc       (acc_reg),
        .acc_next  (acc_dec),
        .res       (dec_res)
    );

    // Lowest pending slot is the next character in symbol order.
    always_comb
    begin
        sel = 2'd0;
        for (int i = SYMS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                sel = 2'(i);
        end
    end

    assign mask_rest  = mask_reg & ~(SYMS'(1) << sel);
    assign text_valid = |mask_reg;
    assign text_char  = chars_reg[sel];
    assign last_of_byte = (mask_rest == '0);
    assign text_fire  = text_valid && !text_stall;

    // Buffer frees up when empty or when its final character leaves now.
    assign buf_free   = !text_valid || (text_fire && last_of_byte);
    assign load       = in_valid_reg && buf_free;
    assign code_stall = in_valid_reg && !load;
    assign code_fire  = code_valid && !code_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (code_fire)
            in_valid_next = 1'b1;
        else if (load)
            in_valid_next = 1'b0;

        mask_next = mask_reg;
        if (load)
            mask_next = dec_res.mask;      // may be empty: beat gave nothing
        else if (text_fire)
            mask_next = mask_rest;

        acc_next = load ? acc_dec : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mask_reg     <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            mask_reg     <= mask_next;
            acc_reg      <= acc_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (code_fire)
            byte_reg <= code_byte;
        if (load)
            chars_reg <= dec_res.chars;
    end

endmodule

// File: hw/rtl/mtbsd_decode.sv
// Combinational decode of one code beat: four symbols against the accumulator.
// Depends on mtbsd_pkg.
`timescale 1ns / 1ps

module mtbsd_decode #(
    parameter int ACC_BITS = mtbsd_pkg::ACC_BITS_DEF
) (
    input  logic [7:0]          code_byte,
    input  logic [ACC_BITS-1:0] acc,
    output logic [ACC_BITS-1:0] acc_next,
    output mtbsd_pkg::mtbsd_res_t res
);
    import mtbsd_pkg::*;

    always_comb
    begin
        logic [ACC_BITS-1:0] a;
        logic [1:0]          sym;
        a   = acc;
        res = '0;
        for (int i = 0; i < SYMS; i++)
        begin
            sym = code_byte[7 - 2*i -: 2];
            case (sym)
                SYM_END:
                begin
                    // zero never matches a table key
                    res.chars[i] = morse_lookup(KEY_W'(a));
                    res.mask[i]  = (res.chars[i] != CHAR_NONE);
                    a            = '0;
                end
                SYM_SPACE:
                begin
                    res.chars[i] = CHAR_SPACE;
                    res.mask[i]  = 1'b1;
                    a            = '0;
                end
                default:
                begin
                    a = {a[ACC_BITS-3:0], sym};
                end
            endcase
        end
        acc_next = a;
    end

endmodule

// File: hw/rtl/mtbsd_checker.sv
// Port-level checker for the Morse decoder core, bound to the top level.
// Depends on mtbsd_pkg and morse_two_bit_symbol_decoder_core_assert.svh.
`timescale 1ns / 1ps

`include "morse_two_bit_symbol_decoder_core_assert.svh"

module mtbsd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         code_valid,
    input logic                         code_stall,
    input logic [7:0]                   code_byte,
    input logic                         text_valid,
    input logic                         text_stall,
    input logic [mtbsd_pkg::CHAR_W-1:0] text_char,
    input logic                         last_of_byte
);
    import mtbsd_pkg::*;

    // held character beat stays put
    `MTBSD_ASSERT_NEXT(a_text_hold, clk, rst_n, text_valid && text_stall, text_valid && $stable(text_char) && $stable(last_of_byte))

    // only space, punctuation, digits and upper case leave the block
    `MTBSD_ASSERT_IMPL(a_char_range, clk, rst_n, text_valid, (text_char >= CHAR_SPACE) && (text_char <= 7'h5A))

    // input backs up only behind a pending character
    `MTBSD_ASSERT_IMPL(a_stall_cause, clk, rst_n, code_stall, text_valid)

    // a character that is not the last of its beat is followed by another
    `MTBSD_ASSERT_NEXT(a_more_follow, clk, rst_n, text_valid && !text_stall && !last_of_byte, text_valid)

endmodule

bind morse_two_bit_symbol_decoder_core mtbsd_checker u_mtbsd_checker (.*);
